FILE: design/delimited_datagram_deframer_assert.svh
// Assertion macros shared by the deframer modules.
`ifndef DELIMITED_DATAGRAM_DEFRAMER_ASSERT_SVH
`define DELIMITED_DATAGRAM_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ddd_pkg.sv
// Types and constants for the delimited datagram deframer.
`timescale 1ns / 1ps

package ddd_pkg;

  localparam int unsigned StreamIdxW = 2;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 8;
  localparam int unsigned WindowW    = 4 * ByteW;
  localparam int unsigned MinFrame   = 4;
  localparam logic [ByteW-1:0] MarkerReset = 8'hFF;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  typedef struct packed {
    logic [StreamIdxW-1:0] stream_index;
    logic [ByteW-1:0]      data_byte;
  } ddd_in_t;

  typedef struct packed {
    logic [StreamIdxW-1:0] source_stream;
    logic [ByteW-1:0]      destination;
    logic [ByteW-1:0]      command_code;
    logic [ByteW-1:0]      argument;
    logic [ByteW-1:0]      datagram_id;
  } ddd_out_t;

  typedef struct packed {
    logic     valid;
    ddd_out_t beat;
  } ddd_push_t;

endpackage

FILE: design/ddd_front.sv
// Front end: per-stream window, count and last-id update; classifies each byte.
`timescale 1ns / 1ps

`include "delimited_datagram_deframer_assert.svh"

module ddd_front #(
  parameter int unsigned NUM_STREAMS     = 4,
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ddd_pkg::ddd_in_t          in_i,
  input  logic [ddd_pkg::ByteW-1:0] marker_i,
  input  logic                      queue_full_i,
  output ddd_pkg::ddd_push_t        push_o
);

  localparam logic [ddd_pkg::CountW-1:0] MaxCount = ddd_pkg::CountW'(MAX_FRAME_BYTES);
  localparam logic [ddd_pkg::CountW-1:0] MinCount = ddd_pkg::CountW'(ddd_pkg::MinFrame);

  logic [ddd_pkg::WindowW-1:0] rec_q [NUM_STREAMS];
  logic [ddd_pkg::CountW-1:0]  cnt_q [NUM_STREAMS];
  logic [ddd_pkg::ByteW-1:0]   lid_q [NUM_STREAMS];

  logic [NUM_STREAMS-1:0]      hit;
  logic [ddd_pkg::WindowW-1:0] sel_rec;
  logic [ddd_pkg::CountW-1:0]  sel_cnt;
  logic [ddd_pkg::ByteW-1:0]   sel_lid;
  logic                        acc;
  logic                        is_marker;
  logic                        long_enough;
  logic                        dup;

  assign in_ready_o = !queue_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign is_marker  = (in_i.data_byte == marker_i);

  // lane select; out-of-range streams hit nothing
  always_comb begin
    sel_rec = '0;
    sel_cnt = '0;
    sel_lid = '0;
    for (int s = 0; s < NUM_STREAMS; s++) begin
      hit[s] = (int'(in_i.stream_index) == s);
      if (hit[s]) begin
        sel_rec = sel_rec | rec_q[s];
        sel_cnt = sel_cnt | cnt_q[s];
        sel_lid = sel_lid | lid_q[s];
      end
    end
  end

  assign long_enough = (sel_cnt >= MinCount);
  assign dup         = (sel_rec[ddd_pkg::ByteW-1:0] == sel_lid);

  always_comb begin
    push_o.valid              = acc && (|hit) && is_marker && long_enough && !dup;
    push_o.beat.source_stream = in_i.stream_index;
    push_o.beat.destination   = sel_rec[31:24];
    push_o.beat.command_code  = sel_rec[23:16];
    push_o.beat.argument      = sel_rec[15:8];
    push_o.beat.datagram_id   = sel_rec[7:0];
  end

  for (genvar g = 0; g < NUM_STREAMS; g++) begin : g_lane
    logic [ddd_pkg::CountW-1:0] cnt_inc;
    assign cnt_inc = cnt_q[g] + 1'b1;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rec_q[g] <= '0;
        cnt_q[g] <= '0;
        lid_q[g] <= '0;
      end else if (acc && hit[g]) begin
        if (!is_marker) begin
          rec_q[g] <= {rec_q[g][ddd_pkg::WindowW-ddd_pkg::ByteW-1:0], in_i.data_byte};
          cnt_q[g] <= (cnt_inc >= MaxCount) ? '0 : cnt_inc;
        end else begin
          cnt_q[g] <= '0;
          if (long_enough && !dup) begin
            lid_q[g] <= rec_q[g][ddd_pkg::ByteW-1:0];
          end
        end
      end
    end

    `DDD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q[g] < MaxCount, "frame count reached maximum")
  end

endmodule

FILE: design/ddd_queue.sv
// Two-entry queue between the front end and the output stage.
`timescale 1ns / 1ps

`include "delimited_datagram_deframer_assert.svh"

module ddd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddd_pkg::ddd_push_t push_i,
  output logic               full_o,
  output logic               nonempty_o,
  input  logic               pop_i,
  output ddd_pkg::ddd_out_t  head_o
);

  ddd_pkg::ddd_out_t                 mem_q [ddd_pkg::QueueDepth];
  logic [ddd_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [ddd_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [ddd_pkg::QueueCntW-1:0]     cnt_q, cnt_d;
  logic                              do_push;
  logic                              do_pop;

  assign full_o     = (cnt_q == ddd_pkg::QueueCntW'(ddd_pkg::QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign do_push    = push_i.valid && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.beat;
    end
  end

  `DDD_ASSERT_NOW(a_no_overflow, push_i.valid, !full_o, "push into full queue")
  `DDD_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= ddd_pkg::QueueCntW'(ddd_pkg::QueueDepth), "queue count out of range")
  `DDD_ASSERT_NEXT(a_fill_track, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "queue count lost a push")

endmodule

FILE: design/ddd_back.sv
// Back end: output register fed from the queue head.
`timescale 1ns / 1ps

module ddd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              nonempty_i,
  input  ddd_pkg::ddd_out_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ddd_pkg::ddd_out_t out_o
);

  logic              out_valid_q;
  ddd_pkg::ddd_out_t out_q;
  logic              slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = slot_free && nonempty_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= nonempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

endmodule

FILE: design/delimited_datagram_deframer.sv
// Top level of the delimited datagram deframer.
`timescale 1ns / 1ps

// Byte-delimited datagram deframer. Each input beat carries one received byte and the
// stream it came in on; every stream keeps its own byte count, a window of its last
// four bytes and the id of its last accepted datagram. When the end marker byte
// (register marker_q, reset 0xFF) arrives on a stream holding at least four bytes,
// the window gives destination, command, argument and id, oldest first; the datagram
// is sent only if its id differs from the stream's stored id, which it then replaces.
// Short frames are dropped; a frame that reaches MAX_FRAME_BYTES without a marker
// restarts its byte count. Streams at or above NUM_STREAMS are ignored. Rate: one
// input beat per cycle while the queue is not full; the per-stream update is a
// read-modify-write of flip-flop state. After its marker beat, a datagram goes
// through the front end into a two-entry queue, and the output register takes it
// from there. The input stalls only when that queue is full. The configuration
// port is always ready; write it only while the block is idle.

module delimited_datagram_deframer #(
  parameter int unsigned NUM_STREAMS     = 4,
  parameter int unsigned MAX_FRAME_BYTES = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ddd_pkg::ddd_in_t          in_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output ddd_pkg::ddd_out_t         out_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ddd_pkg::ByteW-1:0] cfg_data_i
);

  logic [ddd_pkg::ByteW-1:0] marker_q;
  ddd_pkg::ddd_push_t        push;
  ddd_pkg::ddd_out_t         head;
  logic                      queue_full;
  logic                      queue_nonempty;
  logic                      pop;

  // end marker register; a write beat always lands
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= ddd_pkg::MarkerReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      marker_q <= cfg_data_i;
    end
  end

  // front: classify each byte and update its stream's state
  ddd_front #(
    .NUM_STREAMS     (NUM_STREAMS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .marker_i     (marker_q),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  // decoupling queue, so a stalled output does not hold the front up at once
  ddd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (queue_full),
    .nonempty_o (queue_nonempty),
    .pop_i      (pop),
    .head_o     (head)
  );

  // back: output register
  ddd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (queue_nonempty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
